// ===== src/format_specifier_parser_assert.svh =====
// assertion macros for the format specifier parser checker
// depends on nothing; included by the checker file
`ifndef FORMAT_SPECIFIER_PARSER_ASSERT_SVH
`define FORMAT_SPECIFIER_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("format specifier parser check failed");

// next-cycle implication, disabled during reset
`define FSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("format specifier parser check failed");

`endif

// ===== src/fsp_pkg.sv =====
// shared types, codes and character decode for the format specifier parser
// no dependencies
package fsp_pkg;

  localparam int FSP_VALUE_BITS = 16;
  localparam int FSP_OUT_VALUE_BITS = 16;

  // parser phases
  typedef enum logic [3:0] {
    PH_FLAGS = 4'd0,
    PH_WDIG  = 4'd1,
    PH_DOT   = 4'd2,
    PH_PREC  = 4'd3,
    PH_PDIG  = 4'd4,
    PH_LEN   = 4'd5,
    PH_H     = 4'd6,
    PH_L     = 4'd7,
    PH_CONV  = 4'd8
  } fsp_phase_t;

  // width / precision modes
  localparam logic [1:0] MODE_ABSENT  = 2'd0;
  localparam logic [1:0] MODE_LITERAL = 2'd1;
  localparam logic [1:0] MODE_STAR    = 2'd2;

  // length codes
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_HH   = 3'd1;
  localparam logic [2:0] LEN_H    = 3'd2;
  localparam logic [2:0] LEN_LL   = 3'd3;
  localparam logic [2:0] LEN_L    = 3'd4;
  localparam logic [2:0] LEN_J    = 3'd5;
  localparam logic [2:0] LEN_Z    = 3'd6;
  localparam logic [2:0] LEN_T    = 3'd7;

  // conversion codes
  localparam logic [3:0] CONV_D   = 4'd0;
  localparam logic [3:0] CONV_U   = 4'd1;
  localparam logic [3:0] CONV_O   = 4'd2;
  localparam logic [3:0] CONV_X   = 4'd3;
  localparam logic [3:0] CONV_XU  = 4'd4;
  localparam logic [3:0] CONV_C   = 4'd5;
  localparam logic [3:0] CONV_S   = 4'd6;
  localparam logic [3:0] CONV_P   = 4'd7;
  localparam logic [3:0] CONV_N   = 4'd8;
  localparam logic [3:0] CONV_PCT = 4'd9;

  // flag bit positions
  localparam int FLAG_LEFT  = 0;
  localparam int FLAG_SIGN  = 1;
  localparam int FLAG_SPACE = 2;
  localparam int FLAG_ALT   = 3;
  localparam int FLAG_ZERO  = 4;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_XU    = 8'h58;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_J     = 8'h6A;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_Z     = 8'h7A;

  // one result beat
  typedef struct packed {
    logic [4:0]                    flag_bits;
    logic [1:0]                    width_mode;
    logic [FSP_OUT_VALUE_BITS-1:0] width_value;
    logic [1:0]                    precision_mode;
    logic [FSP_OUT_VALUE_BITS-1:0] precision_value;
    logic [2:0]                    length_code;
    logic [3:0]                    conversion;
    logic                          error;
  } fsp_result_t;

  // one-hot flag for a flag character, zero otherwise
  function automatic logic [4:0] fsp_flag_of(input logic [7:0] c);
    logic [4:0] f;
    f = 5'd0;
    case (c)
      CH_MINUS: f[FLAG_LEFT]  = 1'b1;
      CH_PLUS:  f[FLAG_SIGN]  = 1'b1;
      CH_SPACE: f[FLAG_SPACE] = 1'b1;
      CH_HASH:  f[FLAG_ALT]   = 1'b1;
      CH_ZERO:  f[FLAG_ZERO]  = 1'b1;
      default:  f = 5'd0;
    endcase
    return f;
  endfunction

  // conversion letter decode: {known, code}
  function automatic logic [4:0] fsp_conv_of(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      CH_D, CH_I: r = {1'b1, CONV_D};
      CH_U:       r = {1'b1, CONV_U};
      CH_O:       r = {1'b1, CONV_O};
      CH_X:       r = {1'b1, CONV_X};
      CH_XU:      r = {1'b1, CONV_XU};
      CH_C:       r = {1'b1, CONV_C};
      CH_S:       r = {1'b1, CONV_S};
      CH_P:       r = {1'b1, CONV_P};
      CH_N:       r = {1'b1, CONV_N};
      CH_PCT:     r = {1'b1, CONV_PCT};
      default:    r = {1'b0, CONV_D};
    endcase
    return r;
  endfunction

endpackage

// ===== src/fsp_core.sv =====
// parser state and per-character step logic; emits one result when a specifier ends
// depends on fsp_pkg
module fsp_core import fsp_pkg::*; #(
  parameter int VALUE_BITS = FSP_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  ch,
  output logic        emit,
  output fsp_result_t result
);

  fsp_phase_t            phase_r, phase_nxt;
  logic [4:0]            flags_r, flags_nxt;
  logic [VALUE_BITS-1:0] wacc_r, wacc_nxt;
  logic [VALUE_BITS-1:0] pacc_r, pacc_nxt;
  logic [1:0]            wkind_r, wkind_nxt;
  logic [1:0]            pkind_r, pkind_nxt;
  logic [2:0]            len_r, len_nxt;

  logic                  is_digit;
  logic [VALUE_BITS-1:0] digit_val;
  logic [VALUE_BITS-1:0] wacc_step;
  logic [VALUE_BITS-1:0] pacc_step;
  logic [4:0]            flag;
  logic [4:0]            conv;
  logic                  fall_dot, fall_len, fall_conv;
  logic                  fin_err, fin_ok;
  logic [2:0]            len_eff;
  logic [VALUE_BITS+FSP_OUT_VALUE_BITS-1:0] wacc_wide, pacc_wide;

  // character decode and decimal accumulate (acc * 10 + digit, wraps)
  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign digit_val = VALUE_BITS'(ch[3:0]);
  assign wacc_step = (wacc_r << 3) + (wacc_r << 1) + digit_val;
  assign pacc_step = (pacc_r << 3) + (pacc_r << 1) + digit_val;
  assign flag      = fsp_flag_of(ch);
  assign conv      = fsp_conv_of(ch);
  assign wacc_wide = {{FSP_OUT_VALUE_BITS{1'b0}}, wacc_r};
  assign pacc_wide = {{FSP_OUT_VALUE_BITS{1'b0}}, pacc_r};

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAGS;
      flags_r <= 5'd0;
      wacc_r  <= '0;
      pacc_r  <= '0;
      wkind_r <= MODE_ABSENT;
      pkind_r <= MODE_ABSENT;
      len_r   <= LEN_NONE;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      wacc_r  <= wacc_nxt;
      pacc_r  <= pacc_nxt;
      wkind_r <= wkind_nxt;
      pkind_r <= pkind_nxt;
      len_r   <= len_nxt;
    end
  end

  // phase walk: a character that does not fit a phase falls through to later ones
  always_comb begin
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    wacc_nxt  = wacc_r;
    pacc_nxt  = pacc_r;
    wkind_nxt = wkind_r;
    pkind_nxt = pkind_r;
    len_nxt   = len_r;
    fall_dot  = 1'b0;
    fall_len  = 1'b0;
    fall_conv = 1'b0;
    fin_err   = 1'b0;
    fin_ok    = 1'b0;
    len_eff   = len_r;

    if (ch == CH_NUL) begin
      fin_err = 1'b1;
    end else begin
      case (phase_r)
        PH_FLAGS: begin
          if (flag != 5'd0) begin
            if ((flags_r & flag) != 5'd0) fin_err = 1'b1;
            else flags_nxt = flags_r | flag;
          end else if (ch == CH_STAR) begin
            wkind_nxt = MODE_STAR;
            phase_nxt = PH_DOT;
          end else if (is_digit) begin
            wkind_nxt = MODE_LITERAL;
            wacc_nxt  = digit_val;
            phase_nxt = PH_WDIG;
          end else begin
            fall_dot = 1'b1;
          end
        end
        PH_WDIG: begin
          if (is_digit) wacc_nxt = wacc_step;
          else fall_dot = 1'b1;
        end
        PH_DOT: fall_dot = 1'b1;
        PH_PREC: begin
          if (ch == CH_STAR) begin
            pkind_nxt = MODE_STAR;
            phase_nxt = PH_LEN;
          end else if (is_digit) begin
            pkind_nxt = MODE_LITERAL;
            pacc_nxt  = digit_val;
            phase_nxt = PH_PDIG;
          end else begin
            fall_len = 1'b1;
          end
        end
        PH_PDIG: begin
          if (is_digit) pacc_nxt = pacc_step;
          else fall_len = 1'b1;
        end
        PH_LEN: fall_len = 1'b1;
        PH_H: begin
          if (ch == CH_H) begin
            len_nxt   = LEN_HH;
            phase_nxt = PH_CONV;
          end else begin
            len_eff   = LEN_H;
            fall_conv = 1'b1;
          end
        end
        PH_L: begin
          if (ch == CH_L) begin
            len_nxt   = LEN_LL;
            phase_nxt = PH_CONV;
          end else begin
            len_eff   = LEN_L;
            fall_conv = 1'b1;
          end
        end
        default: fall_conv = 1'b1;
      endcase

      // optional precision introducer
      if (fall_dot) begin
        if (ch == CH_DOT) phase_nxt = PH_PREC;
        else fall_len = 1'b1;
      end

      // length letters
      if (fall_len) begin
        case (ch)
          CH_H: phase_nxt = PH_H;
          CH_L: phase_nxt = PH_L;
          CH_J: begin
            len_nxt   = LEN_J;
            phase_nxt = PH_CONV;
          end
          CH_Z: begin
            len_nxt   = LEN_Z;
            phase_nxt = PH_CONV;
          end
          CH_T: begin
            len_nxt   = LEN_T;
            phase_nxt = PH_CONV;
          end
          default: fall_conv = 1'b1;
        endcase
      end

      // conversion letter ends the specifier
      if (fall_conv) begin
        if (conv[4]) fin_ok = 1'b1;
        else fin_err = 1'b1;
      end
    end

    // back to the start after any result
    if (fin_err || fin_ok) begin
      phase_nxt = PH_FLAGS;
      flags_nxt = 5'd0;
      wacc_nxt  = '0;
      pacc_nxt  = '0;
      wkind_nxt = MODE_ABSENT;
      pkind_nxt = MODE_ABSENT;
      len_nxt   = LEN_NONE;
    end
  end

  // result beat
  always_comb begin
    emit   = fin_err || fin_ok;
    result = '0;
    if (fin_err) begin
      result.error = 1'b1;
    end else begin
      result.flag_bits       = flags_r;
      result.width_mode      = wkind_r;
      result.width_value     = (wkind_r == MODE_LITERAL) ?
                               wacc_wide[FSP_OUT_VALUE_BITS-1:0] : '0;
      result.precision_mode  = pkind_r;
      result.precision_value = (pkind_r == MODE_LITERAL) ?
                               pacc_wide[FSP_OUT_VALUE_BITS-1:0] : '0;
      result.length_code     = len_eff;
      result.conversion      = conv[3:0];
      result.error           = 1'b0;
    end
  end

endmodule

// ===== src/format_specifier_parser.sv =====
// top level of the format specifier parser: input register, parser core, result register
// depends on fsp_pkg and fsp_core
//
// Feed the characters after a '%' one beat each on in_ch; a NUL ends the string. The block
// takes one character per cycle, every cycle, for as long as results are taken: a character
// goes into the input register at acceptance and, when it is stepped, the parser core
// advances its state by one step and, if that character finished or broke the specifier,
// writes one result beat into the result register. A result therefore shows on the out_
// port straight from the result register. The rate is set by the one-step
// state update in the core, which carries the phase and the width and precision
// accumulators (times ten plus digit, wrapping at VALUE_BITS) from one character to the
// next. Input stalls only when a result is pending, the result register is full and
// out_ready is low; characters that produce no result keep flowing. An error beat has
// every field zero except out_error.
module format_specifier_parser import fsp_pkg::*; #(
  parameter int VALUE_BITS = FSP_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_flag_bits,
  output logic [1:0]  out_width_mode,
  output logic [15:0] out_width_value,
  output logic [1:0]  out_precision_mode,
  output logic [15:0] out_precision_value,
  output logic [2:0]  out_length_code,
  output logic [3:0]  out_conversion,
  output logic        out_error
);

  logic        s1_valid_r;
  logic [7:0]  ch_r;
  logic        s1_go;
  logic        out_room;
  logic        emit;
  fsp_result_t result;
  logic        out_valid_r;
  fsp_result_t out_r;

  // handshake: the input register moves when its character can be stepped
  assign out_room = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && (!emit || out_room);
  assign in_ready = !s1_valid_r || s1_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r <= in_ch;
    end
  end

  // parser core
  fsp_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_go),
    .ch      (ch_r),
    .emit    (emit),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_r <= result;
    end
  end

  // result beat on the ports
  assign out_valid           = out_valid_r;
  assign out_flag_bits       = out_r.flag_bits;
  assign out_width_mode      = out_r.width_mode;
  assign out_width_value     = out_r.width_value;
  assign out_precision_mode  = out_r.precision_mode;
  assign out_precision_value = out_r.precision_value;
  assign out_length_code     = out_r.length_code;
  assign out_conversion      = out_r.conversion;
  assign out_error           = out_r.error;

endmodule

// ===== src/fsp_checker.sv =====
// port-level checks on the format specifier parser result channel, bound to the top level
// depends on format_specifier_parser_assert.svh and fsp_pkg
`include "format_specifier_parser_assert.svh"

module fsp_checker import fsp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_flag_bits,
  input logic [1:0]  out_width_mode,
  input logic [15:0] out_width_value,
  input logic [1:0]  out_precision_mode,
  input logic [15:0] out_precision_value,
  input logic [2:0]  out_length_code,
  input logic [3:0]  out_conversion,
  input logic        out_error
);

  logic        error_clean;
  logic        values_ok;
  logic        codes_ok;
  logic [48:0] beat;

  // an error beat carries nothing else
  assign error_clean = (out_flag_bits == 5'd0) && (out_width_mode == MODE_ABSENT) &&
                       (out_width_value == 16'd0) && (out_precision_mode == MODE_ABSENT) &&
                       (out_precision_value == 16'd0) && (out_length_code == LEN_NONE) &&
                       (out_conversion == CONV_D);

  // a value is reported only with literal digits
  assign values_ok = (out_width_mode == MODE_LITERAL || out_width_value == 16'd0) &&
                     (out_precision_mode == MODE_LITERAL || out_precision_value == 16'd0);

  // modes and conversion stay within their codes
  assign codes_ok = (out_width_mode != 2'd3) && (out_precision_mode != 2'd3) &&
                    (out_conversion <= CONV_PCT);

  // whole result beat for the hold check
  assign beat = {out_flag_bits, out_width_mode, out_width_value, out_precision_mode,
                 out_precision_value, out_length_code, out_conversion, out_error};

  `FSP_ASSERT_IMP(a_error_clean, clk, rst_n, out_valid && out_error, error_clean)

  `FSP_ASSERT_IMP(a_value_needs_literal, clk, rst_n, out_valid, values_ok)

  `FSP_ASSERT_IMP(a_codes_legal, clk, rst_n, out_valid, codes_ok)

  // a stalled result beat holds
  `FSP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(beat))

endmodule

bind format_specifier_parser fsp_checker u_fsp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_flag_bits       (out_flag_bits),
  .out_width_mode      (out_width_mode),
  .out_width_value     (out_width_value),
  .out_precision_mode  (out_precision_mode),
  .out_precision_value (out_precision_value),
  .out_length_code     (out_length_code),
  .out_conversion      (out_conversion),
  .out_error           (out_error)
);
